@@ rtl/nnsa_pkg.sv @@
package nnsa_pkg;

    // address and size widths
    localparam int ADDR_BITS     = 24;
    localparam int SIZE_BITS     = 12;
    localparam int PITCH_BITS    = 16;
    localparam int ERR_BITS      = SIZE_BITS + 1;
    localparam int PROD_BITS     = SIZE_BITS + PITCH_BITS;
    localparam int CNT_BITS      = $clog2(SIZE_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = ADDR_BITS;
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = ((2 * ADDR_BITS + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SOURCE_BASE   = 3'd0,
        REG_SOURCE_WIDTH  = 3'd1,
        REG_SOURCE_HEIGHT = 3'd2,
        REG_SOURCE_PITCH  = 3'd3,
        REG_TARGET_BASE   = 3'd4,
        REG_TARGET_WIDTH  = 3'd5,
        REG_TARGET_HEIGHT = 3'd6,
        REG_TARGET_PITCH  = 3'd7
    } cfg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic mul;
        logic skip;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_end;
    } status_t;

endpackage

@@ rtl/nnsa_div.sv @@
module nnsa_div
    import nnsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic                 step,
    input  logic [SIZE_BITS-1:0] dividend,
    input  logic [SIZE_BITS-1:0] divisor,
    output logic [SIZE_BITS-1:0] quotient,
    output logic [SIZE_BITS-1:0] remainder
);

    logic [SIZE_BITS-1:0] quo_reg;
    logic [SIZE_BITS-1:0] quo_next;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [SIZE_BITS-1:0] rem_next;
    logic [SIZE_BITS:0]   shifted;
    logic                 fits;

    // load the dividend, or one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SIZE_BITS-1]};
        fits     = (shifted >= {1'b0, divisor});
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            quo_next = {quo_reg[SIZE_BITS-2:0], fits};
            if (fits)
                rem_next = SIZE_BITS'(shifted - {1'b0, divisor});
            else
                rem_next = shifted[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/nnsa_dp.sv @@
module nnsa_dp
    import nnsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  cmd_t                     cmd,
    output status_t                  status,
    output logic [ADDR_BITS-1:0]     read_address,
    output logic [ADDR_BITS-1:0]     write_address,
    output logic                     row_end,
    output logic                     frame_end
);

    // configuration registers
    logic [ADDR_BITS-1:0]  source_base_reg;
    logic [SIZE_BITS-1:0]  source_width_reg;
    logic [SIZE_BITS-1:0]  source_height_reg;
    logic [PITCH_BITS-1:0] source_pitch_reg;
    logic [ADDR_BITS-1:0]  target_base_reg;
    logic [SIZE_BITS-1:0]  target_width_reg;
    logic [SIZE_BITS-1:0]  target_height_reg;
    logic [PITCH_BITS-1:0] target_pitch_reg;

    // walk state
    logic [ADDR_BITS-1:0]  read_pos_reg,    read_pos_next;
    logic [ADDR_BITS-1:0]  write_pos_reg,   write_pos_next;
    logic [SIZE_BITS-1:0]  column_left_reg, column_left_next;
    logic [SIZE_BITS-1:0]  rows_left_reg,   rows_left_next;
    logic [ERR_BITS-1:0]   x_error_reg,     x_error_next;
    logic [ERR_BITS-1:0]   y_error_reg,     y_error_next;
    logic [SIZE_BITS-1:0]  x_quotient_reg;
    logic [SIZE_BITS-1:0]  x_remainder_reg;
    logic [SIZE_BITS-1:0]  y_remainder_reg;
    logic [ADDR_BITS-1:0]  row_skip_reg;
    logic [PROD_BITS-1:0]  prod_reg;

    // result word
    logic [ADDR_BITS-1:0]  read_address_reg;
    logic [ADDR_BITS-1:0]  write_address_reg;
    logic                  row_end_reg;
    logic                  frame_end_reg;

    logic [SIZE_BITS-1:0]  tw;
    logic [SIZE_BITS-1:0]  th;
    logic [SIZE_BITS-1:0]  x_quo;
    logic [SIZE_BITS-1:0]  x_rem;
    logic [SIZE_BITS-1:0]  y_quo;
    logic [SIZE_BITS-1:0]  y_rem;
    logic                  cur_row_end;
    logic                  cur_frame_end;
    logic [ERR_BITS-1:0]   x_sum;
    logic [ERR_BITS-1:0]   y_sum;
    logic                  x_carry;
    logic                  y_carry;
    logic [ADDR_BITS-1:0]  row_add;

    // zero target sizes count as one
    assign tw = (target_width_reg == '0)  ? SIZE_BITS'(1) : target_width_reg;
    assign th = (target_height_reg == '0) ? SIZE_BITS'(1) : target_height_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg   <= '0;
            source_width_reg  <= SIZE_BITS'(1);
            source_height_reg <= SIZE_BITS'(1);
            source_pitch_reg  <= PITCH_BITS'(1);
            target_base_reg   <= '0;
            target_width_reg  <= SIZE_BITS'(1);
            target_height_reg <= SIZE_BITS'(1);
            target_pitch_reg  <= PITCH_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_BASE:   source_base_reg   <= cfg_data[ADDR_BITS-1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_SOURCE_PITCH:  source_pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                REG_TARGET_BASE:   target_base_reg   <= cfg_data[ADDR_BITS-1:0];
                REG_TARGET_WIDTH:  target_width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_TARGET_HEIGHT: target_height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_TARGET_PITCH:  target_pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // size ratio dividers, one quotient bit per cycle each
    nnsa_div u_div_x (
        .clk       (clk),
        .load      (cmd.start),
        .step      (cmd.div_step),
        .dividend  (source_width_reg),
        .divisor   (tw),
        .quotient  (x_quo),
        .remainder (x_rem)
    );

    nnsa_div u_div_y (
        .clk       (clk),
        .load      (cmd.start),
        .step      (cmd.div_step),
        .dividend  (source_height_reg),
        .divisor   (th),
        .quotient  (y_quo),
        .remainder (y_rem)
    );

    // latch ratios, then row skip = y quotient * pitch - source width
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            x_quotient_reg  <= x_quo;
            x_remainder_reg <= x_rem;
            y_remainder_reg <= y_rem;
            prod_reg        <= y_quo * source_pitch_reg;
        end
        if (cmd.skip)
            row_skip_reg <= ADDR_BITS'(prod_reg) - ADDR_BITS'(source_width_reg);
    end

    // one pixel step
    always_comb
    begin
        cur_row_end   = (column_left_reg <= SIZE_BITS'(1));
        cur_frame_end = cur_row_end && (rows_left_reg <= SIZE_BITS'(1));
        x_sum   = x_error_reg + ERR_BITS'(x_remainder_reg);
        x_carry = (x_sum >= {1'b0, tw});
        y_sum   = y_error_reg + ERR_BITS'(y_remainder_reg);
        y_carry = (y_sum >= {1'b0, th});

        row_add = '0;
        if (cur_row_end)
            row_add = row_skip_reg + (y_carry ? ADDR_BITS'(source_pitch_reg) : '0);

        read_pos_next = read_pos_reg + ADDR_BITS'(x_quotient_reg) + row_add
                        + ADDR_BITS'(x_carry);

        if (cur_row_end)
        begin
            write_pos_next   = write_pos_reg + ADDR_BITS'(1) + ADDR_BITS'(target_pitch_reg)
                               - ADDR_BITS'(tw);
            column_left_next = tw;
            x_error_next     = '0;
            rows_left_next   = rows_left_reg - SIZE_BITS'(1);
            y_error_next     = y_carry ? (y_sum - {1'b0, th}) : y_sum;
        end
        else
        begin
            write_pos_next   = write_pos_reg + ADDR_BITS'(1);
            column_left_next = column_left_reg - SIZE_BITS'(1);
            x_error_next     = x_carry ? (x_sum - {1'b0, tw}) : x_sum;
            rows_left_next   = rows_left_reg;
            y_error_next     = y_error_reg;
        end
    end

    // walk state and result word
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            read_pos_reg    <= source_base_reg;
            write_pos_reg   <= target_base_reg;
            column_left_reg <= tw;
            rows_left_reg   <= th;
            x_error_reg     <= '0;
            y_error_reg     <= '0;
        end
        else if (cmd.step)
        begin
            read_pos_reg      <= read_pos_next;
            write_pos_reg     <= write_pos_next;
            column_left_reg   <= column_left_next;
            rows_left_reg     <= rows_left_next;
            x_error_reg       <= x_error_next;
            y_error_reg       <= y_error_next;
            read_address_reg  <= read_pos_reg;
            write_address_reg <= write_pos_reg;
            row_end_reg       <= cur_row_end;
            frame_end_reg     <= cur_frame_end;
        end
    end

    assign status.frame_end = cur_frame_end;
    assign read_address     = read_address_reg;
    assign write_address    = write_address_reg;
    assign row_end          = row_end_reg;
    assign frame_end        = frame_end_reg;

endmodule

@@ rtl/nnsa_ctrl.sv @@
module nnsa_ctrl
    import nnsa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_restart,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t              state_reg,        state_next;
    logic [CNT_BITS-1:0] count_reg,        count_next;
    logic                frame_active_reg, frame_active_next;
    logic                out_valid_reg,    out_valid_next;
    logic                out_free;
    logic                accept;

    assign out_free = !out_valid_reg || out_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            frame_active_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            frame_active_reg <= frame_active_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        frame_active_next = frame_active_reg;
        cmd               = '0;
        in_ready          = 1'b0;
        accept            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    if (in_restart || !frame_active_reg)
                    begin
                        cmd.start  = 1'b1;
                        count_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + CNT_BITS'(1);
                if (count_reg == CNT_BITS'(SIZE_BITS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                cmd.skip   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.step   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.step)
            frame_active_next = !status.frame_end;
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.step)
            out_valid_next = 1'b1;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/nearest_neighbor_scale_addresser_top.sv @@
// Nearest-neighbor scaling address generator for byte images.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one of eight
// registers (bases, widths, heights, pitches); cfg_ready is always high;
// writes must be made only while the block is idle; nothing enforces this.
// Input stream (s_*): each word is one tick; s_tdata bit 0 is restart.
// Output stream (m_*): one word per tick holding the source read address
// and destination write address; m_tlast marks the last pixel of a
// destination row, m_tuser the last pixel of the frame.
// A tick that continues a frame gives its word in the cycle after it is
// accepted, and such ticks are taken one per cycle while the output is not stalled.
// A tick that starts a frame (restart set, or the previous frame finished)
// runs a setup in which two restoring dividers produce one quotient bit
// per cycle for the x and y size ratios, then state ST_MUL multiplies the y
// quotient by the source pitch and ST_SKIP forms the per-row skip. No tick
// is taken during setup.
// Reset: registers return to bases 0 and sizes/pitches 1, no frame is in
// progress, so the first tick always starts a frame.
// Stall: the output word is held while m_tready is low; a new tick is taken
// only when the output register is empty or is being emptied that cycle.
module nearest_neighbor_scale_addresser_top
    import nnsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // input ticks
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [0] restart, rest zero
    // address pairs
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // read_address, write_address
    output logic                     m_tlast,   // row_end
    output logic                     m_tuser    // frame_end
);

    cmd_t                 cmd;
    status_t              status;
    logic [ADDR_BITS-1:0] read_address;
    logic [ADDR_BITS-1:0] write_address;

    assign cfg_ready = 1'b1;

    // sequencer
    nnsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // registers, dividers and address walk
    nnsa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .read_address  (read_address),
        .write_address (write_address),
        .row_end       (m_tlast),
        .frame_end     (m_tuser)
    );

    // pack the output word
    assign m_tdata = OUT_DATA_BITS'({write_address, read_address});

`ifndef SYNTH
    // a tick is only taken when the output register can hold its word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("tick accepted while output word is stalled");

    // the end of a frame is always the end of a row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tuser || m_tlast)
        else $error("frame end without row end");

    // a restart tick enters setup, no tick is taken in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[0] |=> !s_tready)
        else $error("tick taken during frame setup");
`endif

endmodule

@@ tb/tb_nearest_neighbor_scale_addresser_top.sv @@
module tb_nearest_neighbor_scale_addresser_top;
    import nnsa_pkg::*;

    // one expected output word, fields as they leave the block
    typedef struct packed {
        logic [ADDR_BITS-1:0] read_address;
        logic [ADDR_BITS-1:0] write_address;
        logic                 row_end;
        logic                 frame_end;
    } addr_pair_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;   // [0] restart, rest zero
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;          // read_address, write_address
    logic                     m_tlast;          // row_end
    logic                     m_tuser;          // frame_end

    // shadow copy of the configuration registers
    logic [ADDR_BITS-1:0]  src_base   = '0;
    logic [SIZE_BITS-1:0]  src_width  = 1;
    logic [SIZE_BITS-1:0]  src_height = 1;
    logic [PITCH_BITS-1:0] src_stride = 1;
    logic [ADDR_BITS-1:0]  tgt_base   = '0;
    logic [SIZE_BITS-1:0]  tgt_width  = 1;
    logic [SIZE_BITS-1:0]  tgt_height = 1;
    logic [PITCH_BITS-1:0] tgt_pitch  = 1;

    // walker state of the scaler
    logic [ADDR_BITS-1:0] read_pos  = '0;
    logic [ADDR_BITS-1:0] write_pos = '0;
    logic [SIZE_BITS-1:0] cols_left = '0;
    logic [SIZE_BITS-1:0] rows_left = '0;
    logic [ERR_BITS-1:0]  x_err     = '0;
    logic [ERR_BITS-1:0]  y_err     = '0;
    logic [SIZE_BITS-1:0] x_quot    = '0;
    logic [SIZE_BITS-1:0] x_rem     = '0;
    logic [SIZE_BITS-1:0] y_rem     = '0;
    logic [ADDR_BITS-1:0] row_skip  = '0;
    logic                 frame_on  = 1'b0;

    addr_pair_t expected_pairs[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_left       = 0;
    int mismatch_count  = 0;
    int words_checked   = 0;
    int ticks_sent      = 0;
    int restarts_sent   = 0;
    int frame_ends_seen = 0;
    int register_writes = 0;

    nearest_neighbor_scale_addresser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // a zero target size counts as one
    function automatic logic [SIZE_BITS-1:0] eff_size(logic [SIZE_BITS-1:0] size);
        return (size == 0) ? SIZE_BITS'(1) : size;
    endfunction

    // scaler step for one accepted tick, queues the address pair it gives
    function automatic void predict_address_pair(logic restart);
        logic [SIZE_BITS-1:0] tw;
        logic [SIZE_BITS-1:0] th;
        logic [SIZE_BITS-1:0] y_quot;
        logic [63:0]          skip_wide;
        addr_pair_t           pair;
        tw = eff_size(tgt_width);
        th = eff_size(tgt_height);
        // frame setup latches the ratios and reloads the walk
        if (restart || !frame_on)
        begin
            x_quot    = src_width / tw;
            x_rem     = src_width % tw;
            y_quot    = src_height / th;
            y_rem     = src_height % th;
            skip_wide = 64'(y_quot) * 64'(src_stride) - 64'(src_width);
            row_skip  = skip_wide[ADDR_BITS-1:0];
            read_pos  = src_base;
            write_pos = tgt_base;
            cols_left = tw;
            rows_left = th;
            x_err     = '0;
            y_err     = '0;
            frame_on  = 1'b1;
        end
        pair.read_address  = read_pos;
        pair.write_address = write_pos;
        pair.row_end       = (cols_left <= 1);
        pair.frame_end     = pair.row_end && (rows_left <= 1);
        expected_pairs.push_back(pair);
        // column step with x error carry
        read_pos = read_pos + x_quot;
        x_err    = x_err + x_rem;
        if (x_err >= tw)
        begin
            x_err    = x_err - tw;
            read_pos = read_pos + 1'b1;
        end
        write_pos = write_pos + 1'b1;
        cols_left = cols_left - 1'b1;
        // row step with y error carry, sizes and pitches read live
        if (pair.row_end)
        begin
            read_pos = read_pos + row_skip;
            y_err    = y_err + y_rem;
            if (y_err >= th)
            begin
                y_err    = y_err - th;
                read_pos = read_pos + src_stride;
            end
            write_pos = write_pos + tgt_pitch - tw;
            cols_left = tw;
            x_err     = '0;
            rows_left = rows_left - 1'b1;
            if (pair.frame_end)
                frame_on = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [ADDR_BITS-1:0] want,
                                   logic [ADDR_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("word %0d: %s expected 0x%06h got 0x%06h", words_checked, what, want, got);
    endtask

    // output checker
    always @(posedge clk)
    begin : check_words
        addr_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (expected_pairs.size() == 0)
                report_mismatch("unexpected word, read_address", '0, m_tdata[ADDR_BITS-1:0]);
            else
            begin
                want = expected_pairs.pop_front();
                if (m_tdata[ADDR_BITS-1:0] !== want.read_address)
                    report_mismatch("read_address", want.read_address, m_tdata[ADDR_BITS-1:0]);
                if (m_tdata[2*ADDR_BITS-1:ADDR_BITS] !== want.write_address)
                    report_mismatch("write_address", want.write_address,
                                    m_tdata[2*ADDR_BITS-1:ADDR_BITS]);
                if (m_tlast !== want.row_end)
                    report_mismatch("row_end", ADDR_BITS'(want.row_end), ADDR_BITS'(m_tlast));
                if (m_tuser !== want.frame_end)
                    report_mismatch("frame_end", ADDR_BITS'(want.frame_end), ADDR_BITS'(m_tuser));
            end
            if (m_tuser === 1'b1)
                frame_ends_seen++;
        end
    end

    // output ready, random stalls or a counted hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one register write, mirrored into the shadow copy
    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        register_writes++;
        case (idx)
            REG_SOURCE_BASE:   src_base   = value[ADDR_BITS-1:0];
            REG_SOURCE_WIDTH:  src_width  = value[SIZE_BITS-1:0];
            REG_SOURCE_HEIGHT: src_height = value[SIZE_BITS-1:0];
            REG_SOURCE_PITCH:  src_stride = value[PITCH_BITS-1:0];
            REG_TARGET_BASE:   tgt_base   = value[ADDR_BITS-1:0];
            REG_TARGET_WIDTH:  tgt_width  = value[SIZE_BITS-1:0];
            REG_TARGET_HEIGHT: tgt_height = value[SIZE_BITS-1:0];
            REG_TARGET_PITCH:  tgt_pitch  = value[PITCH_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_registers(logic [ADDR_BITS-1:0] sb, logic [SIZE_BITS-1:0] sw,
                                       logic [SIZE_BITS-1:0] sh, logic [PITCH_BITS-1:0] sp,
                                       logic [ADDR_BITS-1:0] tb, logic [SIZE_BITS-1:0] tw,
                                       logic [SIZE_BITS-1:0] th, logic [PITCH_BITS-1:0] tp);
        write_register(REG_SOURCE_BASE, sb);
        write_register(REG_SOURCE_WIDTH, sw);
        write_register(REG_SOURCE_HEIGHT, sh);
        write_register(REG_SOURCE_PITCH, sp);
        write_register(REG_TARGET_BASE, tb);
        write_register(REG_TARGET_WIDTH, tw);
        write_register(REG_TARGET_HEIGHT, th);
        write_register(REG_TARGET_PITCH, tp);
    endtask

    // one input word after a random gap, valid is left high for a follow-on word
    task automatic send_tick(logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, restart};
        do @(posedge clk); while (!s_tready);
        predict_address_pair(restart);
        ticks_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // stop sending and wait for every expected word
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // reset values give one-pixel frames, each tick starts and ends a frame
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_outputs();
    endtask

    task automatic test_directed_scaling();
        // downscale with remainders in x and y
        write_all_registers(24'h000100, 7, 5, 16, 24'h002000, 3, 2, 8);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        drain_outputs();
        // upscale in x, restart in the middle of the frame
        write_all_registers(24'h000300, 2, 2, 3, 24'h004000, 3, 2, 5);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_outputs();
        // largest source sizes, bases and pitches, addresses wrap
        write_all_registers(24'hFFFFFF, 4095, 4095, 16'hFFFF, 24'hFFFFFE, 1, 2, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_outputs();
        // zero target sizes act as one, zero source width and pitch used as is
        write_register(REG_TARGET_WIDTH, 0);
        write_register(REG_TARGET_HEIGHT, 0);
        write_register(REG_SOURCE_WIDTH, 0);
        write_register(REG_SOURCE_PITCH, 0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_outputs();
        // largest target, frame left open
        write_all_registers(24'h000000, 1, 1, 1, 24'h000000, 4095, 4095, 1);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        drain_outputs();
    endtask

    // live sizes and pitches change under a running frame
    task automatic test_midframe_rewrite();
        write_all_registers(24'h000040, 6, 6, 10, 24'h000080, 3, 3, 4);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain_outputs();
        write_register(REG_SOURCE_PITCH, 20);
        write_register(REG_TARGET_PITCH, 9);
        write_register(REG_TARGET_WIDTH, 2);
        write_register(REG_SOURCE_HEIGHT, 9);
        repeat (3) send_tick(1'b0);
        drain_outputs();
    endtask

    // output held off long enough that the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all_registers(24'h001000, 9, 5, 12, 24'h008000, 4, 4, 6);
        hold_left = 80;
        send_tick(1'b1);
        repeat (19) send_tick(1'b0);
        drain_outputs();
    endtask

    task automatic randomize_registers();
        bit wide;
        wide = ($urandom_range(9) == 0);
        write_register(REG_SOURCE_BASE, $urandom_range(24'hFFFFFF));
        write_register(REG_SOURCE_WIDTH, wide ? $urandom_range(4095) : $urandom_range(1, 24));
        write_register(REG_SOURCE_HEIGHT, wide ? $urandom_range(4095) : $urandom_range(1, 24));
        write_register(REG_SOURCE_PITCH, wide ? $urandom_range(65535) : $urandom_range(1, 64));
        write_register(REG_TARGET_BASE, $urandom_range(24'hFFFFFF));
        wide = ($urandom_range(9) == 0);
        write_register(REG_TARGET_WIDTH, wide ? $urandom_range(4095) : $urandom_range(1, 6));
        write_register(REG_TARGET_HEIGHT, wide ? $urandom_range(4095) : $urandom_range(1, 6));
        write_register(REG_TARGET_PITCH, wide ? $urandom_range(65535) : $urandom_range(1, 64));
    endtask

    // mostly whole frames, some cut short or hit by a stray restart
    task automatic test_random_traffic(int items, int send_pct, int recv_pct);
        int sent;
        int frame_len;
        bit cut;
        bit stray;
        bit need_restart;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items)
        begin
            drain_outputs();
            randomize_registers();
            need_restart = 1'b1;
            repeat ($urandom_range(1, 3))
            begin
                frame_len = eff_size(tgt_width) * eff_size(tgt_height);
                cut = ($urandom_range(99) < 15) || (frame_len > 40);
                if (cut)
                    frame_len = $urandom_range(1, (frame_len > 40) ? 40 : frame_len);
                stray = 1'b0;
                for (int t = 0; t < frame_len; t++)
                begin
                    if (t == 0)
                        send_tick(need_restart | 1'($urandom_range(1)));
                    else if ($urandom_range(49) == 0)
                    begin
                        stray = 1'b1;
                        send_tick(1'b1);
                    end
                    else
                        send_tick(1'b0);
                    sent++;
                end
                need_restart = cut || stray;
            end
        end
        drain_outputs();
    endtask

    // run limit
    initial
    begin
        #4000000;
        $display("nearest_neighbor_scale_addresser_top regression: fail");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_scaling();
        test_midframe_rewrite();
        test_output_backpressure();
        test_random_traffic(150, 38, 79);
        test_random_traffic(150, 79, 38);
        test_random_traffic(150, 0, 0);
        repeat (20) @(posedge clk);
        $display("covered %0d ticks (%0d restarts), %0d frame ends, %0d register writes",
                 ticks_sent, restarts_sent, frame_ends_seen, register_writes);
        $display("with input and output stalls, a long output hold-off and mid-frame rewrites");
        if (mismatch_count == 0)
            $display("nearest_neighbor_scale_addresser_top regression: pass");
        else
            $display("nearest_neighbor_scale_addresser_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/nnsa_pkg.sv
rtl/nnsa_div.sv
rtl/nnsa_dp.sv
rtl/nnsa_ctrl.sv
rtl/nearest_neighbor_scale_addresser_top.sv
tb/tb_nearest_neighbor_scale_addresser_top.sv
